// ===== rtl/fpa_pkg.sv =====
// Shared opcodes, status codes and saturation helpers for the fixed-point ALU.
package fpa_pkg;

  typedef enum logic [3:0] {
    FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_GT, FN_LT, FN_GE, FN_LE,
    FN_EQ, FN_NE, FN_MIN, FN_MAX, FN_INC, FN_DEC, FN_TO_INT, FN_FROM_INT
  } func_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  localparam logic [31:0] MAX_VAL = 32'h7fff_ffff;
  localparam logic [31:0] MIN_VAL = 32'h8000_0000;

  // {saturated, value} from sign and magnitude
  function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic [31:0] m;
    m = mag[31:0];
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) return {1'b1, MIN_VAL};
      return {1'b0, 32'(~m + 32'd1)};
    end
    if (mag > 64'h0000_0000_7fff_ffff) return {1'b1, MAX_VAL};
    return {1'b0, m};
  endfunction

  // {saturated, value} from a wide signed value
  function automatic logic [32:0] clamp64(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7fff_ffff) return {1'b1, MAX_VAL};
    if (v < -64'sh0000_0000_8000_0000) return {1'b1, MIN_VAL};
    return {1'b0, v[31:0]};
  endfunction

endpackage

// ===== rtl/fixed_point_alu_q24_8.sv =====
// Every opcode takes the same path from accepted start to out_valid: input register, divider stages, output register.
// Throughput: one beat per cycle; busy stays low, start is taken every cycle.
// Depth is set by the restoring divider, one quotient bit per pipeline stage.
// The receiver cannot stall; each result shows for one cycle with out_valid.
// Reset (rst_n low, synchronous) drops all beats in flight.
module fixed_point_alu_q24_8 import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_func,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic        out_valid,
  output logic signed [31:0] out_result_value,
  output logic        out_compare_true,
  output logic [1:0]  out_status
);

  localparam int W = 33 + FRAC_BITS;

  typedef struct packed {
    logic          vld;
    logic          is_div;
    logic          neg;
    logic [31:0]   rem;
    logic [W-1:0]  dq;
    logic [31:0]   d;
    logic [31:0]   res;
    logic          cmp;
    logic [1:0]    st;
  } stg_t;

  stg_t        s1_r, s1_nxt;
  logic        mul1_r;
  logic [63:0] p1_r;
  stg_t        stg_r [1:W];
  stg_t        stg_nxt [1:W];

  logic [31:0] am, bm;
  logic [32:0] cl;
  func_t       fn;

  assign busy = 1'b0;
  assign fn   = func_t'(in_func);
  assign am   = in_operand_a[31] ? 32'(~in_operand_a + 32'd1) : in_operand_a;
  assign bm   = in_operand_b[31] ? 32'(~in_operand_b + 32'd1) : in_operand_b;

  always_comb begin
    s1_nxt        = '0;
    s1_nxt.vld    = start;
    s1_nxt.neg    = in_operand_a[31] ^ in_operand_b[31];
    s1_nxt.d      = bm;
    s1_nxt.dq     = W'({am, {(FRAC_BITS + 1){1'b0}}});
    s1_nxt.st     = ST_OK;
    cl            = '0;
    case (fn)
      FN_ADD:      cl = clamp64(64'(in_operand_a) + 64'(in_operand_b));
      FN_SUB:      cl = clamp64(64'(in_operand_a) - 64'(in_operand_b));
      FN_INC:      cl = clamp64(64'(in_operand_a) + 64'sd1);
      FN_DEC:      cl = clamp64(64'(in_operand_a) - 64'sd1);
      FN_FROM_INT: cl = clamp64(64'(in_operand_a) <<< FRAC_BITS);
      FN_TO_INT:   cl = {1'b0, 32'(in_operand_a >>> FRAC_BITS)};
      FN_MIN:      cl = {1'b0, (in_operand_a < in_operand_b) ? in_operand_a : in_operand_b};
      FN_MAX:      cl = {1'b0, (in_operand_a > in_operand_b) ? in_operand_a : in_operand_b};
      FN_GT:       s1_nxt.cmp = in_operand_a > in_operand_b;
      FN_LT:       s1_nxt.cmp = in_operand_a < in_operand_b;
      FN_GE:       s1_nxt.cmp = in_operand_a >= in_operand_b;
      FN_LE:       s1_nxt.cmp = in_operand_a <= in_operand_b;
      FN_EQ:       s1_nxt.cmp = in_operand_a == in_operand_b;
      FN_NE:       s1_nxt.cmp = in_operand_a != in_operand_b;
      FN_DIV: begin
        if (bm == 32'd0) s1_nxt.st = ST_DZ;
        else             s1_nxt.is_div = 1'b1;
      end
      default: cl = '0;
    endcase
    s1_nxt.res = cl[31:0];
    if (cl[32]) s1_nxt.st = ST_SAT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else begin
      s1_r <= s1_nxt;
    end
    mul1_r <= (fn == FN_MUL);
    p1_r   <= 64'(am) * 64'(bm);
  end

  logic [63:0] mq;
  logic [32:0] ms;
  assign mq = (p1_r + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign ms = sat_mag(s1_r.neg, mq);

  for (genvar k = 1; k <= W; k++) begin : g_div
    stg_t        src;
    logic [32:0] trial;
    logic        qb;
    if (k == 1) begin : g_first
      always_comb begin
        src = s1_r;
        if (mul1_r) begin
          src.res = ms[31:0];
          src.st  = ms[32] ? ST_SAT : ST_OK;
        end
      end
    end else begin : g_rest
      assign src = stg_r[k-1];
    end
    always_comb begin
      trial      = {src.rem, src.dq[W-1]};
      qb         = trial >= {1'b0, src.d};
      stg_nxt[k] = src;
      stg_nxt[k].rem = qb ? 32'(trial - {1'b0, src.d}) : trial[31:0];
      stg_nxt[k].dq  = {src.dq[W-2:0], qb};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_r[k] <= '0;
      end else begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  logic [W:0]  qr;
  logic [32:0] ds;
  assign qr = ({1'b0, stg_r[W].dq} + (W+1)'(1)) >> 1;
  assign ds = sat_mag(stg_r[W].neg, 64'(qr));

  logic        out_valid_r;
  logic [31:0] out_res_r;
  logic        out_cmp_r;
  logic [1:0]  out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stg_r[W].vld;
    end
    out_cmp_r <= stg_r[W].cmp;
    if (stg_r[W].is_div) begin
      out_res_r <= ds[31:0];
      out_st_r  <= ds[32] ? ST_SAT : ST_OK;
    end else begin
      out_res_r <= stg_r[W].res;
      out_st_r  <= stg_r[W].st;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_compare_true = out_cmp_r;
  assign out_status       = out_st_r;

`ifndef NO_ASSERTIONS
  a_cmp_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compare_true |-> out_status == ST_OK && out_result_value == 32'd0)
    else $error("compare result with nonzero value or status");
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DZ |-> out_result_value == 32'd0 && !out_compare_true)
    else $error("divide by zero with nonzero result");
  a_st_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SAT |->
      out_result_value == MAX_VAL || out_result_value == MIN_VAL)
    else $error("saturated result not at a bound");
`endif

endmodule

// ===== bench/fixed_point_alu_q24_8_tb.sv =====
// Testbench for the Q24.8 fixed-point ALU: directed and random operations with a predictor.
`timescale 1ns / 100ps

module fixed_point_alu_q24_8_tb;
  import fpa_pkg::*;

  localparam int FB = 8;
  localparam int LATENCY = FB + 34;

  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
    logic [1:0]  st;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [3:0] in_func = '0;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic out_valid;
  logic signed [31:0] out_result_value;
  logic out_compare_true;
  logic [1:0] out_status;

  alu_result_t pending_results[$];
  int errors = 0;
  int send_idle_pct = 0;

  fixed_point_alu_q24_8 #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_result_value(out_result_value),
    .out_compare_true(out_compare_true), .out_status(out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic alu_result_t from_sign_mag(input bit neg, input logic [63:0] mag);
    alu_result_t r;
    r = '0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin r.value = 32'h8000_0000; r.st = ST_SAT; end
      else r.value = 32'(-mag);
    end else begin
      if (mag > 64'h7fff_ffff) begin r.value = 32'h7fff_ffff; r.st = ST_SAT; end
      else r.value = mag[31:0];
    end
    return r;
  endfunction

  function automatic alu_result_t clamp_wide(input longint v);
    alu_result_t r;
    r = '0;
    if (v > 64'sh7fff_ffff) begin r.value = 32'h7fff_ffff; r.st = ST_SAT; end
    else if (v < -64'sh8000_0000) begin r.value = 32'h8000_0000; r.st = ST_SAT; end
    else r.value = v[31:0];
    return r;
  endfunction

  function automatic alu_result_t alu_predict(input func_t f, input logic [31:0] ua,
                                              input logic [31:0] ub);
    alu_result_t r;
    longint a, b;
    logic [63:0] ma, mb, p, q, n;
    a = longint'(signed'(ua));
    b = longint'(signed'(ub));
    ma = a < 0 ? 64'(-a) : 64'(a);
    mb = b < 0 ? 64'(-b) : 64'(b);
    r = '0;
    case (f)
      FN_ADD: r = clamp_wide(a + b);
      FN_SUB: r = clamp_wide(a - b);
      FN_MUL: begin
        p = ma * mb;
        q = (p + (64'd1 << (FB - 1))) >> FB;
        r = from_sign_mag((a < 0) != (b < 0), q);
      end
      FN_DIV: begin
        if (b == 0) r.st = ST_DZ;
        else begin
          n = ma << FB;
          q = (2 * n + mb) / (2 * mb);
          r = from_sign_mag((a < 0) != (b < 0), q);
        end
      end
      FN_GT: r.cmp = a > b;
      FN_LT: r.cmp = a < b;
      FN_GE: r.cmp = a >= b;
      FN_LE: r.cmp = a <= b;
      FN_EQ: r.cmp = a == b;
      FN_NE: r.cmp = a != b;
      FN_MIN: r.value = (a < b) ? ua : ub;
      FN_MAX: r.value = (a > b) ? ua : ub;
      FN_INC: r = clamp_wide(a + 1);
      FN_DEC: r = clamp_wide(a - 1);
      FN_TO_INT: r.value = 32'(signed'(ua) >>> FB);
      default: r = clamp_wide(a * (64'sd1 <<< FB));
    endcase
    return r;
  endfunction

  // Drive one beat and hold until accepted.
  task automatic send_op(input func_t f, input logic [31:0] a, input logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_func <= f;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(alu_predict(f, a, b));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    alu_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result value=%h", out_result_value);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_result_value !== exp_r.value) begin
          $error("result_value exp %h got %h", exp_r.value, out_result_value);
          errors++;
        end
        if (out_compare_true !== exp_r.cmp) begin
          $error("compare_true exp %b got %b", exp_r.cmp, out_compare_true);
          errors++;
        end
        if (out_status !== exp_r.st) begin
          $error("status exp %0d got %0d", exp_r.st, out_status);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff - $urandom_range(3);
      1: return 32'h8000_0000 + $urandom_range(3);
      2: return $urandom_range(1023) - 512;
      3: return $urandom_range(65535) << 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_extremes();
    logic [31:0] vals[6] = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                             32'h0000_0100};
    for (int i = 0; i < 16; i++) send_op(func_t'(i), vals[i % 6], vals[(i + 2) % 6]);
    send_op(FN_DIV, 32'h0000_0500, 32'h0);
    send_op(FN_DIV, 32'h7fff_ffff, 32'h1);
    send_op(FN_MUL, 32'h0000_0180, 32'hffff_ff80);
    send_op(FN_MIN, 32'h0000_1234, 32'h0000_1234);
    send_op(FN_MAX, 32'hffff_0000, 32'hffff_0000);
    send_op(FN_TO_INT, 32'hffff_ff01, 32'hffff_ffff);
    send_op(FN_INC, 32'h7fff_ffff, 32'h0);
    send_op(FN_DEC, 32'h8000_0000, 32'h0);
    send_op(FN_FROM_INT, 32'hff80_0000, 32'h0);
    drain_results();
  endtask

  task automatic test_random(input int count, input int idle_pct);
    send_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) send_op(func_t'($urandom_range(15)), rand_operand(),
                                            ($urandom_range(15) == 0) ? 32'h0 : rand_operand());
    send_idle_pct = 0;
  endtask

  task automatic test_pause_for_drain();
    send_op(FN_DIV, $urandom, $urandom);
    drain_results();
    send_op(FN_MUL, $urandom, $urandom);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_random(180, 12);
    test_pause_for_drain();
    test_random(180, 47);
    test_random(180, 0);
    drain_results();
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
